/* rtl/core/brc_pkg.sv */
// ============================================================================
// brc_pkg
// Shared constants, request codes, helper functions and the rotor control
// struct used across the byte rotor cipher.
// ============================================================================
package brc_pkg;

	localparam int MAX_ROTORS  = 5;
	localparam int RIDX_W      = (MAX_ROTORS > 1) ? $clog2(MAX_ROTORS) : 1;
	localparam int CNT_W       = $clog2(MAX_ROTORS + 1);
	localparam int BYTE_W      = 8;
	localparam int TBL_AW      = RIDX_W + BYTE_W;
	localparam int TBL_DEPTH   = MAX_ROTORS * 256;
	localparam int PERIOD_W    = 30;
	localparam int REQ_TYPE_W  = 2;
	localparam int ROTOR_IDX_W = 3;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 3;

	localparam logic [PERIOD_W-1:0] PERIOD_LIMIT = PERIOD_W'(1000000000);

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_LOAD    = 2'd0,
		REQ_STEP    = 2'd1,
		REQ_PROCESS = 2'd2,
		REQ_NONE    = 2'd3
	} req_kind_t;

	localparam logic [CFG_IDX_W-1:0] CFG_DECIPHER    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_COUNT = 2'd1;

	// Control from the sequencer into the rotor state bank
	typedef struct packed {
		logic                set;
		logic [RIDX_W-1:0]   set_idx;
		logic [PERIOD_W-1:0] period;
		logic [BYTE_W-1:0]   advance;
		logic                tick;
		logic [RIDX_W-1:0]   tick_idx;
	} rotor_ctl_t;

	function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
		logic [PERIOD_W-1:0] r;
		r = p;
		if (p == '0) begin
			r = PERIOD_W'(1);
		end else if (p > PERIOD_LIMIT) begin
			r = PERIOD_LIMIT;
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_DATA_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = CNT_W'(v);
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (int'(v) > MAX_ROTORS) begin
			r = CNT_W'(MAX_ROTORS);
		end
		return r;
	endfunction

endpackage

/* rtl/core/brc_if.sv */
// ============================================================================
// brc_if
// Handshake channels of the byte rotor cipher: request, response and
// configuration write.
// ============================================================================
interface brc_req_if import brc_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [REQ_TYPE_W-1:0]  req_type;
	logic [ROTOR_IDX_W-1:0] rotor_index;
	logic [BYTE_W-1:0]      table_position;
	logic [BYTE_W-1:0]      data_byte;
	logic [PERIOD_W-1:0]    step_period;
	logic [BYTE_W-1:0]      step_advance;

	modport source (output valid, req_type, rotor_index, table_position, data_byte,
		step_period, step_advance, input ready);
	modport sink (input valid, req_type, rotor_index, table_position, data_byte,
		step_period, step_advance, output ready);
endinterface

interface brc_rsp_if import brc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] result_byte;

	modport source (output valid, result_byte, input ready);
	modport sink (input valid, result_byte, output ready);
endinterface

interface brc_cfg_if import brc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/core/brc_table_ram.sv */
// ============================================================================
// brc_table_ram
// Single-port-write, single-port-read synchronous RAM with registered read
// data. Read data holds while no read is issued.
// ============================================================================
module brc_table_ram #(
	parameter int DEPTH = 1280,
	parameter int AW    = 11,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/brc_rotor_bank.sv */
// ============================================================================
// brc_rotor_bank
// Per-rotor stepping state: offset, period counter, period and advance.
// Each rotor lane updates itself on a setting or a tick; one offset read port.
// ============================================================================
module brc_rotor_bank import brc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  rotor_ctl_t        ctl,
	input  logic [RIDX_W-1:0] rd_idx,
	output logic [BYTE_W-1:0] rd_offset
);

	logic [BYTE_W-1:0]   offset_q  [MAX_ROTORS];
	logic [PERIOD_W-1:0] counter_q [MAX_ROTORS];
	logic [PERIOD_W-1:0] period_q  [MAX_ROTORS];
	logic [BYTE_W-1:0]   advance_q [MAX_ROTORS];
	logic [PERIOD_W-1:0] count_nxt [MAX_ROTORS];

	// counter stays below period, so the increment fits the field
	always_comb begin
		for (int r = 0; r < MAX_ROTORS; r++) begin
			count_nxt[r] = counter_q[r] + PERIOD_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROTORS; r++) begin
				offset_q[r]  <= '0;
				counter_q[r] <= '0;
				period_q[r]  <= PERIOD_W'(1);
				advance_q[r] <= '0;
			end
		end else begin
			for (int r = 0; r < MAX_ROTORS; r++) begin
				if (ctl.set && ctl.set_idx == RIDX_W'(r)) begin
					period_q[r]  <= ctl.period;
					advance_q[r] <= ctl.advance;
					offset_q[r]  <= '0;
					counter_q[r] <= '0;
				end else if (ctl.tick && ctl.tick_idx == RIDX_W'(r)) begin
					if (count_nxt[r] >= period_q[r]) begin
						offset_q[r]  <= offset_q[r] + advance_q[r];
						counter_q[r] <= '0;
					end else begin
						counter_q[r] <= count_nxt[r];
					end
				end
			end
		end
	end

	always_comb begin
		rd_offset = '0;
		for (int r = 0; r < MAX_ROTORS; r++) begin
			if (rd_idx == RIDX_W'(r)) begin
				rd_offset = offset_q[r];
			end
		end
	end

endmodule

/* rtl/core/byte_rotor_cipher.sv */
// ============================================================================
// byte_rotor_cipher
// Byte rotor cipher with up to MAX_ROTORS substitution rotors held in one
// table memory, walked one rotor per cycle by a small sequencer.
// ============================================================================
// A table load or a stepping setting is applied on acceptance, without a
// rotor walk. A process item is walked from acceptance to the result register:
// the accept cycle issues the read of the first rotor's table entry, and each
// following cycle consumes one rotor's read data and issues the next rotor's
// read through the single read port of the table memory. A new item is taken
// in the cycle after the last rotor step, so a byte is never accepted while a
// walk is still running. The result waits in an output register while
// further items are accepted; a walk that finishes while that result still
// waits holds its last step until the result is taken. The tables are not
// cleared at reset; load every entry that a byte can reach before processing.
// Configuration is taken at any time with ready held high and is meant to
// change only while idle.
module byte_rotor_cipher import brc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	brc_req_if.sink     req,
	brc_rsp_if.source   rsp,
	brc_cfg_if.sink     cfg
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [RIDX_W-1:0] cur_q;
	logic              mode_q;
	logic [CNT_W-1:0]  count_q;
	logic              rsp_valid_q;
	logic [BYTE_W-1:0] rsp_byte_q;

	logic              req_fire;
	logic              idx_ok;
	logic [RIDX_W-1:0] req_rotor;
	logic [RIDX_W-1:0] last_rotor;
	logic [RIDX_W-1:0] first_rotor;
	logic [RIDX_W-1:0] next_rotor;
	logic              last_step;
	logic              hold;
	logic              walk_done;
	logic [BYTE_W-1:0] step_byte;
	logic [BYTE_W-1:0] addr_byte;

	logic              tbl_we;
	logic [TBL_AW-1:0] tbl_waddr;
	logic              tbl_re;
	logic [TBL_AW-1:0] tbl_raddr;
	logic [BYTE_W-1:0] tbl_rdata;

	logic [RIDX_W-1:0] rd_idx;
	logic [BYTE_W-1:0] rd_offset;
	rotor_ctl_t        rctl;

	assign req.ready   = (state_q == ST_IDLE);
	assign req_fire    = req.valid && req.ready;
	assign idx_ok      = int'(req.rotor_index) < MAX_ROTORS;
	assign req_rotor   = req.rotor_index[RIDX_W-1:0];
	assign last_rotor  = RIDX_W'(count_q - CNT_W'(1));
	assign first_rotor = mode_q ? last_rotor : '0;
	assign next_rotor  = mode_q ? (cur_q - RIDX_W'(1)) : (cur_q + RIDX_W'(1));
	assign last_step   = mode_q ? (cur_q == '0) : (cur_q == last_rotor);
	assign hold        = last_step && rsp_valid_q && !rsp.ready;
	assign walk_done   = (state_q == ST_RUN) && last_step && !hold;

	// decipher uses the current rotor's offset, encipher the next rotor's
	assign rd_idx    = (state_q == ST_IDLE) ? '0 : (mode_q ? cur_q : next_rotor);
	assign step_byte = mode_q ? (tbl_rdata - rd_offset) : tbl_rdata;

	always_comb begin
		addr_byte = (state_q == ST_IDLE) ? req.data_byte : step_byte;
		if (!mode_q) begin
			addr_byte = addr_byte + rd_offset;
		end
	end

	assign tbl_we    = req_fire && req.req_type == REQ_LOAD && idx_ok;
	assign tbl_waddr = {req_rotor, req.table_position};
	assign tbl_re    = (state_q == ST_IDLE) ? (req_fire && req.req_type == REQ_PROCESS)
		: !last_step;
	assign tbl_raddr = (state_q == ST_IDLE) ? {first_rotor, addr_byte}
		: {next_rotor, addr_byte};

	always_comb begin
		rctl          = '0;
		rctl.set      = req_fire && req.req_type == REQ_STEP && idx_ok;
		rctl.set_idx  = req_rotor;
		rctl.period   = clamp_period(req.step_period);
		rctl.advance  = req.step_advance;
		rctl.tick     = (state_q == ST_RUN) && !hold;
		rctl.tick_idx = cur_q;
	end

	brc_table_ram #(
		.DEPTH (TBL_DEPTH),
		.AW    (TBL_AW),
		.DW    (BYTE_W)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (req.data_byte),
		.re    (tbl_re),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	brc_rotor_bank u_rotors (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (rctl),
		.rd_idx    (rd_idx),
		.rd_offset (rd_offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cur_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (walk_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire && req.req_type == REQ_PROCESS) begin
						state_q <= ST_RUN;
						cur_q   <= first_rotor;
					end
				end
				ST_RUN: begin
					if (!last_step) begin
						cur_q <= next_rotor;
					end else if (!hold) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (walk_done) begin
			rsp_byte_q <= step_byte;
		end
	end

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			count_q <= CNT_W'(1);
		end else if (cfg.valid) begin
			if (cfg.index == CFG_DECIPHER) begin
				mode_q <= cfg.data[0];
			end else if (cfg.index == CFG_ROTOR_COUNT) begin
				count_q <= clamp_count(cfg.data);
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_byte = rsp_byte_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_we && tbl_re))
		else $error("table write and read in the same cycle");

	a_cur_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> CNT_W'(cur_q) < count_q)
		else $error("rotor walk left the active chain");

	a_tick_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		rctl.tick |-> state_q == ST_RUN && !rctl.set)
		else $error("rotor tick outside a process walk");

	a_process_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.req_type == REQ_PROCESS) |=> state_q == ST_RUN)
		else $error("process item did not start a rotor walk");

	a_result_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_RUN && state_q == ST_IDLE)
		else $error("result raised without finishing a walk");

endmodule

/* tb/rotor_cipher_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// rotor_cipher_checker
// Watches the request, response and configuration channels of the byte rotor
// cipher. Keeps its own copy of the rotor state, predicts each result byte
// and checks the response stream against it in order.
// ============================================================================
module rotor_cipher_checker import brc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	brc_req_if   req,
	brc_rsp_if   rsp,
	brc_cfg_if   cfg,
	output int   mismatches,
	output int   pending
);

	logic [BYTE_W-1:0]   rotor_table [MAX_ROTORS][256];
	logic [BYTE_W-1:0]   rotor_offset [MAX_ROTORS];
	logic [PERIOD_W-1:0] rotor_period [MAX_ROTORS];
	logic [PERIOD_W-1:0] bytes_since_advance [MAX_ROTORS];
	logic [BYTE_W-1:0]   rotor_advance [MAX_ROTORS];
	logic                deciphering;
	int                  active_rotors;
	logic [BYTE_W-1:0]   expected_bytes [$];

	initial begin
		mismatches = 0;
		pending = 0;
	end

	// Count one byte through rotor r; advance its offset at the end of a period.
	task automatic step_rotor(input int r);
		logic [PERIOD_W:0] next;
		next = {1'b0, bytes_since_advance[r]} + 1'b1;
		if (next >= {1'b0, rotor_period[r]}) begin
			rotor_offset[r] = rotor_offset[r] + rotor_advance[r];
			next = '0;
		end
		bytes_since_advance[r] = next[PERIOD_W-1:0];
	endtask

	// Apply one accepted request to the rotor state and work out its result byte.
	task automatic predict_rotor_output(output bit has_result, output logic [BYTE_W-1:0] y);
		logic [PERIOD_W-1:0] per;
		logic [BYTE_W-1:0]   b;
		logic [BYTE_W-1:0]   pos;
		int                  ri;
		has_result = 1'b0;
		y = '0;
		ri = int'(req.rotor_index);
		case (req_kind_t'(req.req_type))
			REQ_LOAD: begin
				if (ri < MAX_ROTORS)
					rotor_table[ri][req.table_position] = req.data_byte;
			end
			REQ_STEP: begin
				if (ri < MAX_ROTORS) begin
					per = req.step_period;
					if (per == '0)
						per = PERIOD_W'(1);
					else if (per > PERIOD_LIMIT)
						per = PERIOD_LIMIT;
					rotor_period[ri] = per;
					rotor_advance[ri] = req.step_advance;
					rotor_offset[ri] = '0;
					bytes_since_advance[ri] = '0;
				end
			end
			REQ_PROCESS: begin
				b = req.data_byte;
				if (!deciphering) begin
					for (int r = 0; r < active_rotors; r++) begin
						pos = b + rotor_offset[r];
						b = rotor_table[r][pos];
						step_rotor(r);
					end
				end else begin
					for (int r = active_rotors - 1; r >= 0; r--) begin
						b = rotor_table[r][b] - rotor_offset[r];
						step_rotor(r);
					end
				end
				y = b;
				has_result = 1'b1;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [BYTE_W-1:0] want;
		bit                has_result;
		if (!arst_n) begin
			for (int r = 0; r < MAX_ROTORS; r++) begin
				rotor_offset[r] = '0;
				rotor_period[r] = PERIOD_W'(1);
				bytes_since_advance[r] = '0;
				rotor_advance[r] = '0;
			end
			deciphering = 1'b0;
			active_rotors = 1;
			expected_bytes.delete();
		end else begin
			// check responses before queueing this edge's request
			if (rsp.valid && rsp.ready) begin
				if (expected_bytes.size() == 0) begin
					if (mismatches < 50)
						$display("%0t: result_byte expected none, got %02h",
							$time, rsp.result_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (rsp.result_byte !== want) begin
						if (mismatches < 50)
							$display("%0t: result_byte expected %02h, got %02h",
								$time, want, rsp.result_byte);
						mismatches++;
					end
				end
			end
			if (req.valid && req.ready) begin
				predict_rotor_output(has_result, want);
				if (has_result)
					expected_bytes.push_back(want);
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DECIPHER: begin
						deciphering = cfg.data[0];
					end
					CFG_ROTOR_COUNT: begin
						if (cfg.data == '0)
							active_rotors = 1;
						else if (int'(cfg.data) > MAX_ROTORS)
							active_rotors = MAX_ROTORS;
						else
							active_rotors = int'(cfg.data);
					end
					default: ;
				endcase
			end
		end
		pending = expected_bytes.size();
	end

endmodule

/* tb/byte_rotor_cipher_test.sv */
`timescale 1ns / 1ps
// ============================================================================
// byte_rotor_cipher_test
// Loads every rotor table with a random permutation, runs a short directed
// sequence over the edge cases, then random traffic across several rotor
// counts and both directions with varying backpressure. A checker beside the
// block predicts and compares every result byte.
// ============================================================================
module byte_rotor_cipher_test;
	import brc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	// per-segment settings; rotor count writes include values that clamp
	localparam logic [26:0] COUNT_SEQ =
		{3'd5, 3'd6, 3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd1};
	localparam logic [8:0]  MODE_SEQ  = 9'b1_0110_1010;

	logic clk;
	logic arst_n;
	int   src_idle_pct;
	int   sink_stall_pct;
	int   mismatches;
	int   pending;

	brc_req_if req_ch ();
	brc_rsp_if rsp_ch ();
	brc_cfg_if cfg_ch ();

	byte_rotor_cipher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	rotor_cipher_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg        (cfg_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic send_request(input req_kind_t kind, input logic [ROTOR_IDX_W-1:0] ri,
		input logic [BYTE_W-1:0] pos, input logic [BYTE_W-1:0] data,
		input logic [PERIOD_W-1:0] period, input logic [BYTE_W-1:0] adv);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid          <= 1'b1;
		req_ch.req_type       <= kind;
		req_ch.rotor_index    <= ri;
		req_ch.table_position <= pos;
		req_ch.data_byte      <= data;
		req_ch.step_period    <= period;
		req_ch.step_advance   <= adv;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
	endtask

	// Drop valid, wait for every outstanding result, then let loads settle.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [BYTE_W-1:0]      perm [256];
		logic [BYTE_W-1:0]      tmp;
		logic [PERIOD_W-1:0]    period;
		logic [ROTOR_IDX_W-1:0] ri;
		req_kind_t              kind;
		int                     j;
		int                     sel;
		int                     pick;

		src_idle_pct = 25;
		sink_stall_pct = 66;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_NONE;
		req_ch.rotor_index = '0;
		req_ch.table_position = '0;
		req_ch.data_byte = '0;
		req_ch.step_period = '0;
		req_ch.step_advance = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_DECIPHER;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill every table so no byte can reach an unwritten entry
		for (int r = 0; r < MAX_ROTORS; r++) begin
			for (int i = 0; i < 256; i++)
				perm[i] = BYTE_W'(i);
			for (int i = 255; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = perm[i];
				perm[i] = perm[j];
				perm[j] = tmp;
			end
			for (int i = 0; i < 256; i++)
				send_request(REQ_LOAD, ROTOR_IDX_W'(r), BYTE_W'(i), perm[i],
					PERIOD_W'($urandom), BYTE_W'($urandom));
		end

		// directed: extremes, clamping, ignored rotors, unknown request
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h00, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd7, 8'hFF, 8'hFF, '1, 8'hFF);
		send_request(REQ_STEP, 3'd0, 8'h00, 8'h00, '0, 8'hFF);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h5A, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'hA5, '0, 8'h00);
		send_request(REQ_STEP, 3'd0, 8'h00, 8'h00, '1, 8'h01);
		send_request(REQ_STEP, 3'd1, 8'h00, 8'h00, PERIOD_W'(1000000000), 8'h80);
		send_request(REQ_STEP, 3'd2, 8'h00, 8'h00, PERIOD_W'(1000000001), 8'h7F);
		send_request(REQ_STEP, 3'd3, 8'h00, 8'h00, PERIOD_W'(2), 8'h01);
		send_request(REQ_STEP, 3'd5, 8'h00, 8'h00, PERIOD_W'(1), 8'h10);
		send_request(REQ_LOAD, 3'd7, 8'hFF, 8'h00, '0, 8'h00);
		send_request(REQ_NONE, 3'd1, 8'h3C, 8'hC3, '1, 8'hFF);
		send_request(REQ_LOAD, 3'd4, 8'hFF, 8'h00, '0, 8'h00);
		send_request(REQ_LOAD, 3'd0, 8'h00, 8'hFF, '0, 8'h00);
		write_register(CFG_ROTOR_COUNT, 3'd7);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h00, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'hFF, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h80, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h01, '0, 8'h00);
		write_register(CFG_DECIPHER, 3'd1);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h00, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'hFF, '0, 8'h00);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h7E, '0, 8'h00);
		write_register(CFG_ROTOR_COUNT, 3'd0);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h42, '0, 8'h00);
		write_register(CFG_SPARE_A, 3'd7);
		write_register(CFG_SPARE_B, 3'd0);
		send_request(REQ_PROCESS, 3'd0, 8'h00, 8'h81, '0, 8'h00);

		// random traffic: three segments per backpressure pattern
		for (int seg = 0; seg < 9; seg++) begin
			if (seg == 3) begin
				src_idle_pct = 66;
				sink_stall_pct = 25;
			end else if (seg == 6) begin
				src_idle_pct = 0;
				sink_stall_pct = 0;
			end
			write_register(CFG_DECIPHER, {2'($urandom_range(3)), MODE_SEQ[seg]});
			write_register(CFG_ROTOR_COUNT, COUNT_SEQ[3*seg +: 3]);
			repeat (122) begin
				sel = $urandom_range(99);
				ri = ROTOR_IDX_W'($urandom_range(MAX_ROTORS - 1));
				if (sel < 68) begin
					kind = REQ_PROCESS;
					ri = ROTOR_IDX_W'($urandom);
				end else if (sel < 80) begin
					kind = REQ_STEP;
				end else if (sel < 90) begin
					kind = REQ_LOAD;
				end else if (sel < 95) begin
					kind = sel[0] ? REQ_LOAD : REQ_STEP;
					ri = ROTOR_IDX_W'($urandom_range(7, MAX_ROTORS));
				end else begin
					kind = REQ_NONE;
				end
				pick = $urandom_range(99);
				if (pick < 55)
					period = PERIOD_W'($urandom_range(1, 4));
				else if (pick < 70)
					period = PERIOD_W'($urandom_range(5, 300));
				else if (pick < 80)
					period = '0;
				else if (pick < 92)
					period = PERIOD_W'($urandom);
				else
					period = PERIOD_W'($urandom_range(999999999, 1000000001));
				send_request(kind, ri, BYTE_W'($urandom), BYTE_W'($urandom), period,
					BYTE_W'($urandom));
			end
		end

		drain();
		if (mismatches == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sim.f */
rtl/core/brc_pkg.sv
rtl/core/brc_if.sv
rtl/core/brc_table_ram.sv
rtl/core/brc_rotor_bank.sv
rtl/core/byte_rotor_cipher.sv
tb/rotor_cipher_checker.sv
tb/byte_rotor_cipher_test.sv
